[rtl/adts_pkg.sv]
// Shared types and constants for the ADTS frame extractor.
// Used by the front end, the command queue, the back end and the top level.
package adts_pkg;

  // Header store sizing
  localparam int HEADER_MAX_BYTES = 10;
  localparam int HDR_IDX_W        = $clog2(HEADER_MAX_BYTES);
  localparam int HDR_CNT_W        = $clog2(HEADER_MAX_BYTES + 1);

  // Frame length field
  localparam int LEN_W = 13;

  // Command queue sizing
  localparam int CMD_FIFO_DEPTH = 4;
  localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
  localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

  // Sync pattern
  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [7:0] SYNC2_MASK  = 8'hF6;
  localparam logic [7:0] SYNC2_VALUE = 8'hF0;
  localparam logic [7:0] PROT_ABSENT = 8'h01;
  localparam logic [7:0] ID_BIT      = 8'h08;

  // Header sizes in bits
  localparam int HDR_BITS_BASE   = 56;
  localparam int HDR_BITS_LEGACY = 58;
  localparam int HDR_BITS_CRC    = 16;

  // Fixed header byte positions
  localparam int BYTE_SYNC1   = 0;
  localparam int BYTE_SYNC2   = 1;
  localparam int BYTE_LEN_HI  = 3;
  localparam int BYTE_LEN_MID = 4;
  localparam int BYTE_LEN_LO  = 5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEGACY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP  = 1'd1;

  // Result status codes
  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT_FF,
    PH_HUNT_2ND,
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_EMIT,
    CMD_EMIT2,
    CMD_REPLAY
  } cmd_kind_t;

  typedef enum logic [1:0] {
    B_CMD,
    B_SECOND,
    B_READ,
    B_SEND
  } back_state_t;

  // One command from the front end to the back end
  typedef struct packed {
    logic                 store;
    logic [HDR_IDX_W-1:0] idx;
    logic [7:0]           sbyte;
    cmd_kind_t            kind;
    logic [7:0]           b0;
    logic [7:0]           b1;
    logic                 last;
    logic [1:0]           status;
  } cmd_t;

endpackage

[rtl/adts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module adts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/adts_front.sv]
// Front end: sync hunt, header collection and payload classification.
// Holds the configuration registers; depends on adts_pkg.
module adts_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [7:0]                     in_byte,
  input  logic                           cfg_write,
  input  logic [adts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data,
  output logic                           cmd_push,
  output adts_pkg::cmd_t                 cmd
);

  adts_pkg::phase_t phase, phase_next;

  logic legacy_layout, strip_header;

  logic [adts_pkg::HDR_CNT_W-1:0] count, count_next;
  logic [adts_pkg::HDR_CNT_W-1:0] target, target_next;
  logic                           unal, unal_next;
  logic                           carry_ok, carry_ok_next;
  logic [7:0]                     carry, carry_next;
  logic [adts_pkg::LEN_W-1:0]     pl, pl_next;
  logic [7:0]                     len_hi, len_hi_next;
  logic [7:0]                     len_mid, len_mid_next;
  logic [7:0]                     len_lo, len_lo_next;

  // Byte classification
  logic is_ff, is_sync2;
  assign is_ff    = (in_byte == adts_pkg::SYNC_BYTE);
  assign is_sync2 = ((in_byte & adts_pkg::SYNC2_MASK) == adts_pkg::SYNC2_VALUE);

  // Header size from the second sync byte
  logic       crc, mpeg4_odd, size_clip, size_unal;
  logic [6:0] size_bits;
  logic [3:0] size_raw;
  logic [adts_pkg::HDR_CNT_W-1:0] size_target;

  assign crc       = ((in_byte & adts_pkg::PROT_ABSENT) == 8'd0);
  assign mpeg4_odd = legacy_layout && ((in_byte & adts_pkg::ID_BIT) == 8'd0);
  assign size_bits = (mpeg4_odd ? 7'(adts_pkg::HDR_BITS_LEGACY) : 7'(adts_pkg::HDR_BITS_BASE))
                   + (crc ? 7'(adts_pkg::HDR_BITS_CRC) : 7'd0);
  assign size_raw    = 4'((size_bits + 7'd7) >> 3);
  assign size_clip   = int'(size_raw) > adts_pkg::HEADER_MAX_BYTES;
  assign size_target = size_clip ? adts_pkg::HDR_CNT_W'(adts_pkg::HEADER_MAX_BYTES)
                                 : adts_pkg::HDR_CNT_W'(size_raw);
  assign size_unal   = (size_bits[2:0] != 3'd0);

  // Header completion and frame length
  logic                       hdr_done, is_short, pl_zero, go_payload;
  logic [adts_pkg::LEN_W-1:0] flen, pl_calc, pl_dec;
  logic [adts_pkg::HDR_CNT_W-1:0] count_inc;
  logic [7:0]                 carry_in, realigned;

  assign count_inc  = count + adts_pkg::HDR_CNT_W'(1);
  assign hdr_done   = (count_inc >= target);
  assign flen       = unal ? {len_mid, len_lo[7:3]} : {len_hi[1:0], len_mid, len_lo[7:5]};
  assign is_short   = (flen < adts_pkg::LEN_W'(target));
  assign pl_calc    = flen - adts_pkg::LEN_W'(target);
  assign pl_zero    = (pl_calc == '0);
  assign go_payload = !is_short && !pl_zero;
  assign pl_dec     = pl - adts_pkg::LEN_W'(1);
  assign carry_in   = {in_byte[5:0], 2'b00};
  assign realigned  = carry | {6'd0, in_byte[7:6]};

  // Next phase
  always_comb begin
    phase_next = phase;
    if (in_valid) begin
      unique case (phase)
        adts_pkg::PH_HUNT_FF: begin
          if (is_ff) phase_next = adts_pkg::PH_HUNT_2ND;
        end
        adts_pkg::PH_HUNT_2ND: begin
          if (is_sync2) phase_next = adts_pkg::PH_HEADER;
          else if (is_ff) phase_next = adts_pkg::PH_HUNT_2ND;
          else phase_next = adts_pkg::PH_HUNT_FF;
        end
        adts_pkg::PH_HEADER: begin
          if (hdr_done) phase_next = go_payload ? adts_pkg::PH_PAYLOAD : adts_pkg::PH_HUNT_FF;
        end
        adts_pkg::PH_PAYLOAD: begin
          if (pl_dec == '0) phase_next = adts_pkg::PH_HUNT_FF;
        end
        default: phase_next = adts_pkg::PH_HUNT_FF;
      endcase
    end
  end

  // Commands and frame state
  always_comb begin
    cmd_push      = 1'b0;
    cmd           = '0;
    count_next    = count;
    target_next   = target;
    unal_next     = unal;
    carry_ok_next = carry_ok;
    carry_next    = carry;
    pl_next       = pl;
    len_hi_next   = len_hi;
    len_mid_next  = len_mid;
    len_lo_next   = len_lo;
    if (in_valid) begin
      unique case (phase)
        adts_pkg::PH_HUNT_FF: begin
          if (is_ff) begin
            cmd_push  = 1'b1;
            cmd.store = 1'b1;
            cmd.idx   = adts_pkg::HDR_IDX_W'(adts_pkg::BYTE_SYNC1);
            cmd.sbyte = in_byte;
          end
        end
        adts_pkg::PH_HUNT_2ND: begin
          if (is_sync2) begin
            cmd_push      = 1'b1;
            cmd.store     = 1'b1;
            cmd.idx       = adts_pkg::HDR_IDX_W'(adts_pkg::BYTE_SYNC2);
            cmd.sbyte     = in_byte;
            count_next    = adts_pkg::HDR_CNT_W'(adts_pkg::BYTE_SYNC2 + 1);
            target_next   = size_target;
            unal_next     = size_unal;
            carry_ok_next = !size_clip;
          end else if (is_ff) begin
            cmd_push  = 1'b1;
            cmd.store = 1'b1;
            cmd.idx   = adts_pkg::HDR_IDX_W'(adts_pkg::BYTE_SYNC1);
            cmd.sbyte = in_byte;
          end
        end
        adts_pkg::PH_HEADER: begin
          // capture the length bytes as they pass
          if (count == adts_pkg::HDR_CNT_W'(adts_pkg::BYTE_LEN_HI))  len_hi_next  = in_byte;
          if (count == adts_pkg::HDR_CNT_W'(adts_pkg::BYTE_LEN_MID)) len_mid_next = in_byte;
          if (count == adts_pkg::HDR_CNT_W'(adts_pkg::BYTE_LEN_LO))  len_lo_next  = in_byte;
          count_next = count_inc;
          if (!hdr_done) begin
            cmd_push  = 1'b1;
            cmd.store = 1'b1;
            cmd.idx   = count[adts_pkg::HDR_IDX_W-1:0];
            cmd.sbyte = in_byte;
          end else if (is_short) begin
            cmd_push   = 1'b1;
            cmd.kind   = adts_pkg::CMD_EMIT;
            cmd.last   = 1'b1;
            cmd.status = adts_pkg::ST_SHORT;
            unal_next  = 1'b0;
          end else begin
            pl_next = pl_calc;
            if (strip_header) begin
              if (unal) begin
                // final header byte holds the partial bits
                carry_next = carry_ok ? carry_in : 8'd0;
                if (pl_zero) begin
                  cmd_push   = 1'b1;
                  cmd.kind   = adts_pkg::CMD_EMIT;
                  cmd.b0     = carry_ok ? carry_in : 8'd0;
                  cmd.last   = 1'b1;
                  cmd.status = adts_pkg::ST_DATA;
                  unal_next  = 1'b0;
                end
              end else if (pl_zero) begin
                cmd_push   = 1'b1;
                cmd.kind   = adts_pkg::CMD_EMIT;
                cmd.last   = 1'b1;
                cmd.status = adts_pkg::ST_EMPTY;
              end
            end else begin
              // store the final byte and replay the whole header
              cmd_push  = 1'b1;
              cmd.store = 1'b1;
              cmd.idx   = count[adts_pkg::HDR_IDX_W-1:0];
              cmd.sbyte = in_byte;
              cmd.kind  = adts_pkg::CMD_REPLAY;
              cmd.last  = pl_zero;
              unal_next = 1'b0;
            end
          end
        end
        adts_pkg::PH_PAYLOAD: begin
          pl_next  = pl_dec;
          cmd_push = 1'b1;
          if (unal) begin
            cmd.b0 = realigned;
            if (pl_dec == '0) begin
              cmd.kind  = adts_pkg::CMD_EMIT2;
              cmd.b1    = carry_in;
              cmd.last  = 1'b1;
              unal_next = 1'b0;
            end else begin
              cmd.kind   = adts_pkg::CMD_EMIT;
              carry_next = carry_in;
            end
          end else begin
            cmd.kind = adts_pkg::CMD_EMIT;
            cmd.b0   = in_byte;
            cmd.last = (pl_dec == '0);
          end
        end
        default: ;
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      legacy_layout <= 1'b0;
      strip_header  <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        adts_pkg::CFG_LEGACY: legacy_layout <= cfg_data;
        adts_pkg::CFG_STRIP:  strip_header  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= adts_pkg::PH_HUNT_FF;
      count    <= '0;
      target   <= adts_pkg::HDR_CNT_W'(adts_pkg::HEADER_MAX_BYTES);
      unal     <= 1'b0;
      carry_ok <= 1'b1;
      carry    <= '0;
      pl       <= '0;
    end else begin
      phase    <= phase_next;
      count    <= count_next;
      target   <= target_next;
      unal     <= unal_next;
      carry_ok <= carry_ok_next;
      carry    <= carry_next;
      pl       <= pl_next;
    end
  end

  // Length bytes need no reset
  always_ff @(posedge clk) begin
    len_hi  <= len_hi_next;
    len_mid <= len_mid_next;
    len_lo  <= len_lo_next;
  end

  // Header collection stays inside the sized header
  a_hdr_count: assert property (@(posedge clk) disable iff (rst)
    (phase == adts_pkg::PH_HEADER) |->
      (count < target) && (count > adts_pkg::HDR_CNT_W'(adts_pkg::BYTE_SYNC2)))
    else $error("header count outside the header");

endmodule

[rtl/adts_cmd_fifo.sv]
// Short command queue between the front end and the back end.
// Depends on adts_pkg for the command type and depth.
module adts_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  adts_pkg::cmd_t wr_cmd,
  input  logic           rd_en,
  output adts_pkg::cmd_t head,
  output logic           valid,
  output logic           full
);

  adts_pkg::cmd_t entries [adts_pkg::CMD_FIFO_DEPTH];

  logic [adts_pkg::CMD_PTR_W-1:0] wptr, rptr;
  logic [adts_pkg::CMD_CNT_W-1:0] fill;

  assign head  = entries[rptr];
  assign valid = (fill != '0);
  assign full  = (fill == adts_pkg::CMD_CNT_W'(adts_pkg::CMD_FIFO_DEPTH));

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (wr_en) wptr <= wptr + adts_pkg::CMD_PTR_W'(1);
      if (rd_en) rptr <= rptr + adts_pkg::CMD_PTR_W'(1);
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + adts_pkg::CMD_CNT_W'(1);
        2'b01:   fill <= fill - adts_pkg::CMD_CNT_W'(1);
        default: ;
      endcase
    end
  end

  // Hold the word at the write pointer
  always_ff @(posedge clk) begin
    if (wr_en) entries[wptr] <= wr_cmd;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !wr_en || rd_en)
    else $error("command queue overflow");

endmodule

[rtl/adts_back.sv]
// Back end: executes queued commands into result words and replays headers.
// Instantiates adts_ram for the header store; depends on adts_pkg.
module adts_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  adts_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           pop,
  output logic           out_valid,
  output logic [7:0]     out_byte,
  output logic           last_of_frame,
  output logic [1:0]     status
);

  adts_pkg::back_state_t state, state_next;

  logic [adts_pkg::HDR_IDX_W-1:0] ptr, ptr_next;
  logic [adts_pkg::HDR_IDX_W-1:0] last_idx, last_idx_next;
  logic                           rlast, rlast_next;
  logic [7:0]                     second, second_next;

  logic       slot_free, load;
  logic [7:0] load_byte;
  logic       load_last;
  logic [1:0] load_status;
  logic       ram_we, ram_re;
  logic [7:0] ram_rdata;
  logic       at_end;

  assign slot_free = !out_valid || pop;
  assign at_end    = (ptr == last_idx);

  adts_ram #(
    .WIDTH(8),
    .DEPTH(adts_pkg::HEADER_MAX_BYTES)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cmd.idx),
    .wdata(cmd.sbyte),
    .re   (ram_re),
    .raddr(ptr),
    .rdata(ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      adts_pkg::B_CMD: begin
        if (cmd_valid) begin
          if (cmd.kind == adts_pkg::CMD_REPLAY) state_next = adts_pkg::B_READ;
          else if (cmd.kind == adts_pkg::CMD_EMIT2 && slot_free) state_next = adts_pkg::B_SECOND;
        end
      end
      adts_pkg::B_SECOND: if (slot_free) state_next = adts_pkg::B_CMD;
      adts_pkg::B_READ:   state_next = adts_pkg::B_SEND;
      adts_pkg::B_SEND: begin
        if (slot_free) state_next = at_end ? adts_pkg::B_CMD : adts_pkg::B_READ;
      end
      default: state_next = adts_pkg::B_CMD;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    cmd_pop       = 1'b0;
    load          = 1'b0;
    load_byte     = '0;
    load_last     = 1'b0;
    load_status   = adts_pkg::ST_DATA;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ptr_next      = ptr;
    last_idx_next = last_idx;
    rlast_next    = rlast;
    second_next   = second;
    unique case (state)
      adts_pkg::B_CMD: begin
        if (cmd_valid) begin
          // a repeated write while stalled stores the same byte again
          ram_we = cmd.store;
          unique case (cmd.kind)
            adts_pkg::CMD_NONE: cmd_pop = 1'b1;
            adts_pkg::CMD_EMIT: begin
              if (slot_free) begin
                cmd_pop     = 1'b1;
                load        = 1'b1;
                load_byte   = cmd.b0;
                load_last   = cmd.last;
                load_status = cmd.status;
              end
            end
            adts_pkg::CMD_EMIT2: begin
              if (slot_free) begin
                cmd_pop     = 1'b1;
                load        = 1'b1;
                load_byte   = cmd.b0;
                second_next = cmd.b1;
              end
            end
            adts_pkg::CMD_REPLAY: begin
              cmd_pop       = 1'b1;
              ptr_next      = '0;
              last_idx_next = cmd.idx;
              rlast_next    = cmd.last;
            end
            default: ;
          endcase
        end
      end
      adts_pkg::B_SECOND: begin
        if (slot_free) begin
          load      = 1'b1;
          load_byte = second;
          load_last = 1'b1;
        end
      end
      adts_pkg::B_READ: ram_re = 1'b1;
      adts_pkg::B_SEND: begin
        if (slot_free) begin
          load      = 1'b1;
          load_byte = ram_rdata;
          load_last = rlast && at_end;
          if (!at_end) ptr_next = ptr + adts_pkg::HDR_IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= adts_pkg::B_CMD;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  // Output word and replay registers
  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    last_idx <= last_idx_next;
    rlast    <= rlast_next;
    second   <= second_next;
    if (load) begin
      out_byte      <= load_byte;
      last_of_frame <= load_last;
      status        <= load_status;
    end
  end

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command taken from an empty queue");

  a_second_held: assert property (@(posedge clk) disable iff (rst)
    (state == adts_pkg::B_SECOND) |-> out_valid)
    else $error("second realigned word without the first");

  a_replay_range: assert property (@(posedge clk) disable iff (rst)
    (state == adts_pkg::B_READ || state == adts_pkg::B_SEND) |-> (ptr <= last_idx))
    else $error("replay pointer past the header");

endmodule

[rtl/adts_frame_extractor.sv]
// Top level of the ADTS frame extractor.
// Instantiates adts_front, adts_cmd_fifo and adts_back; depends on adts_pkg.
//
// Usage
//   Input queue: drive in_byte and raise push; a word is taken on each edge
//   with push high and full low. Result queue: while empty is low the oldest
//   result sits on out_byte, last_of_frame and status; pop high with empty
//   low takes it. Configuration: cfg_write with cfg_index and cfg_data
//   writes legacy_layout (index 0) or strip_header (index 1). Throughput:
//   one input word per cycle while the command queue has room. A realigned
//   last payload word gives two results, the second from B_SECOND; a header
//   replay alternates B_READ and B_SEND per result, set by the registered
//   read of the header store. An accepted word reaches its first result
//   via the command queue and the output register, a replay also via B_READ
//   and B_SEND. Reset clears the hunt state, the queue and the output
//   register and restores legacy_layout 0, strip_header 1. The header store
//   is not cleared. When the receiver stalls, the output register holds, the
//   back end stops, the queue fills and full rises to hold off the sender.
module adts_frame_extractor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     in_byte,
  input  logic                           cfg_write,
  input  logic [adts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     out_byte,
  output logic                           last_of_frame,
  output logic [1:0]                     status
);

  logic           in_valid;
  logic           cmd_push, cmd_pop, cmd_valid;
  adts_pkg::cmd_t cmd_in, cmd_head;
  logic           out_valid;

  assign in_valid = push && !full;
  assign empty    = !out_valid;

  adts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  adts_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cmd_push),
    .wr_cmd(cmd_in),
    .rd_en (cmd_pop),
    .head  (cmd_head),
    .valid (cmd_valid),
    .full  (full)
  );

  adts_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd_head),
    .cmd_pop      (cmd_pop),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .last_of_frame(last_of_frame),
    .status       (status)
  );

endmodule

[bench/adts_frame_checker.sv]
`timescale 1ns / 1ps
// Checker for the ADTS frame extractor: follows every accepted byte through its own
// deframer state and compares each popped result word field by field.
// Depends on adts_pkg; instantiated beside the block by adts_frame_extractor_tb.
module adts_frame_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic                           full,
  input  logic [7:0]                     in_byte,
  input  logic                           cfg_write,
  input  logic [adts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data,
  input  logic                           empty,
  input  logic                           pop,
  input  logic [7:0]                     out_byte,
  input  logic                           last_of_frame,
  input  logic [1:0]                     status,
  output int                             fail_count,
  output int                             pending,
  output int                             words_checked,
  output logic                           between_frames
);
  import adts_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic [1:0] code;
  } frame_word_t;

  // Deframer state as this side sees it
  phase_t           phase;
  logic [7:0]       hdr_bytes [HEADER_MAX_BYTES];
  logic [3:0]       hdr_count;
  logic [3:0]       hdr_target;
  logic [3:0]       partial_idx;
  logic [LEN_W-1:0] payload_left;
  logic [7:0]       carry;
  logic             unaligned;
  logic             cfg_legacy;
  logic             cfg_strip;

  frame_word_t expected_words [$];
  frame_word_t got_word;
  frame_word_t want_word;
  int          mismatch_total;
  int          popped_total;

  function automatic void queue_word(input logic [7:0] value, input logic last,
                                     input logic [1:0] code);
    expected_words.push_back({value, last, code});
  endfunction

  // Work out header size and alignment from the second sync byte
  function automatic void size_header(input logic [7:0] b1);
    int bits;
    bits = (cfg_legacy && (b1 & ID_BIT) == 0) ? HDR_BITS_LEGACY : HDR_BITS_BASE;
    if ((b1 & PROT_ABSENT) == 0) bits += HDR_BITS_CRC;
    hdr_target  = 4'(((bits + 7) / 8 > HEADER_MAX_BYTES) ? HEADER_MAX_BYTES : (bits + 7) / 8);
    unaligned   = (bits % 8) != 0;
    partial_idx = 4'(bits / 8);
  endfunction

  // Header complete: decode the length and emit what the frame start calls for
  function automatic void close_header();
    logic [LEN_W-1:0] flen;
    if (unaligned)
      flen = {hdr_bytes[BYTE_LEN_MID], hdr_bytes[BYTE_LEN_LO][7:3]};
    else
      flen = {hdr_bytes[BYTE_LEN_HI][1:0], hdr_bytes[BYTE_LEN_MID],
              hdr_bytes[BYTE_LEN_LO][7:5]};
    phase = PH_HUNT_FF;
    if (flen < hdr_target) begin
      unaligned = 1'b0;
      carry = '0;
      queue_word(8'h00, 1'b1, ST_SHORT);
      return;
    end
    payload_left = flen - hdr_target;
    if (cfg_strip) begin
      if (unaligned) begin
        // the partial header byte seeds the realignment carry
        carry = hdr_bytes[partial_idx] << 2;
        if (payload_left == 0) begin
          queue_word(carry, 1'b1, ST_DATA);
          carry = '0;
          unaligned = 1'b0;
          return;
        end
      end else if (payload_left == 0) begin
        carry = '0;
        queue_word(8'h00, 1'b1, ST_EMPTY);
        return;
      end
    end else begin
      unaligned = 1'b0;
      for (int i = 0; i < hdr_target; i++)
        queue_word(hdr_bytes[i], payload_left == 0 && i == hdr_target - 1, ST_DATA);
      if (payload_left == 0) begin
        carry = '0;
        return;
      end
    end
    if (!unaligned) carry = '0;
    phase = PH_PAYLOAD;
  endfunction

  // Advance the deframer by one accepted byte
  function automatic void deframe_byte(input logic [7:0] b);
    logic retest;
    retest = 1'b0;
    case (phase)
      PH_PAYLOAD: begin
        payload_left = payload_left - 1'b1;
        if (unaligned) begin
          queue_word(carry | (b >> 6), 1'b0, ST_DATA);
          carry = b << 2;
          if (payload_left == 0) begin
            queue_word(carry, 1'b1, ST_DATA);
            carry = '0;
            unaligned = 1'b0;
            phase = PH_HUNT_FF;
          end
        end else begin
          queue_word(b, payload_left == 0, ST_DATA);
          if (payload_left == 0) phase = PH_HUNT_FF;
        end
      end
      PH_HEADER: begin
        hdr_bytes[hdr_count] = b;
        hdr_count = hdr_count + 1'b1;
        if (hdr_count >= hdr_target) close_header();
      end
      PH_HUNT_2ND: begin
        if ((b & SYNC2_MASK) == SYNC2_VALUE) begin
          hdr_bytes[BYTE_SYNC2] = b;
          hdr_count = 4'd2;
          size_header(b);
          phase = PH_HEADER;
        end else begin
          // drop back to hunting and give this byte a second look
          phase = PH_HUNT_FF;
          retest = 1'b1;
        end
      end
      default: retest = 1'b1;
    endcase
    if (retest && b == SYNC_BYTE) begin
      hdr_bytes[BYTE_SYNC1] = b;
      phase = PH_HUNT_2ND;
    end
  endfunction

  // Compare popped words, apply register writes, predict from accepted bytes
  always @(posedge clk) begin
    if (rst) begin
      phase        = PH_HUNT_FF;
      hdr_count    = '0;
      hdr_target   = 4'd10;
      partial_idx  = '0;
      payload_left = '0;
      carry        = '0;
      unaligned    = 1'b0;
      cfg_legacy   = 1'b0;
      cfg_strip    = 1'b1;
      expected_words.delete();
      mismatch_total = 0;
      popped_total   = 0;
    end else begin
      if (pop && !empty) begin
        got_word = {out_byte, last_of_frame, status};
        popped_total++;
        if (expected_words.size() == 0) begin
          if (mismatch_total < 10)
            $display("%0t: word %0d not expected: byte %02h last %0b status %0d", $time,
                     popped_total, got_word.value, got_word.last, got_word.code);
          mismatch_total++;
        end else begin
          want_word = expected_words.pop_front();
          if (got_word.value !== want_word.value || got_word.last !== want_word.last ||
              got_word.code !== want_word.code) begin
            if (mismatch_total < 10)
              $display({"%0t: word %0d expected byte %02h last %0b status %0d,",
                        " got byte %02h last %0b status %0d"}, $time, popped_total,
                       want_word.value, want_word.last, want_word.code,
                       got_word.value, got_word.last, got_word.code);
            mismatch_total++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_LEGACY: cfg_legacy = cfg_data;
          CFG_STRIP:  cfg_strip  = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) deframe_byte(in_byte);
    end
    fail_count     <= mismatch_total;
    pending        <= expected_words.size();
    words_checked  <= popped_total;
    between_frames <= (phase == PH_HUNT_FF);
  end

endmodule

[bench/adts_frame_extractor_tb.sv]
`timescale 1ns / 1ps
// Testbench top for adts_frame_extractor: clock, reset, byte stream stimulus,
// register settings, result draining and the verdict.
// Depends on adts_pkg and adts_frame_checker.
module adts_frame_extractor_tb;
  import adts_pkg::*;

  localparam int RUN_LIMIT     = 1_000_000;
  localparam int RANDOM_WORDS  = 200;
  localparam int RANDOM_PHASES = 5;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_FLEN      = (1 << LEN_W) - 1;

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic [7:0]           in_byte;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic                 cfg_data;
  logic                 empty;
  logic                 pop;
  logic [7:0]           out_byte;
  logic                 last_of_frame;
  logic [1:0]           status;

  int   fail_count;
  int   pending;
  int   words_checked;
  logic between_frames;

  // Stimulus bookkeeping
  bit cfg_legacy_now;
  bit sender_steady;
  bit stall_request;
  int cycle_count    = 0;
  int sent_words     = 0;
  int frame_words    = 0;
  int frame_count    = 0;
  int short_count    = 0;
  int miss_count     = 0;
  int settings_count = 0;

  adts_frame_extractor dut (.*);

  adts_frame_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .in_byte        (in_byte),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .last_of_frame  (last_of_frame),
    .status         (status),
    .fail_count     (fail_count),
    .pending        (pending),
    .words_checked  (words_checked),
    .between_frames (between_frames)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", RUN_LIMIT, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one word and hold it until the block takes it
  task automatic send_word(input logic [7:0] b);
    int gap;
    gap = sender_steady ? 0 : idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (full);
    @(negedge clk);
    sent_words++;
  endtask

  // Build one frame for the current layout; short_len writes a length below the header
  task automatic send_frame(input bit mpeg2_id, input bit with_crc, input int body_len,
                            input bit short_len);
    logic [7:0]       hdr [HEADER_MAX_BYTES];
    logic [LEN_W-1:0] flen;
    int               bits;
    int               nbytes;
    bit               realign;
    bits = (cfg_legacy_now && !mpeg2_id) ? HDR_BITS_LEGACY : HDR_BITS_BASE;
    if (with_crc) bits += HDR_BITS_CRC;
    nbytes  = (bits + 7) / 8;
    realign = (bits % 8) != 0;
    if (short_len) body_len = 0;
    if (nbytes + body_len > MAX_FLEN) body_len = MAX_FLEN - nbytes;
    flen = short_len ? LEN_W'($urandom_range(0, nbytes - 1)) : LEN_W'(nbytes + body_len);
    for (int i = 0; i < nbytes; i++) hdr[i] = 8'($urandom_range(0, 255));
    hdr[BYTE_SYNC1] = SYNC_BYTE;
    hdr[BYTE_SYNC2] = SYNC2_VALUE | (mpeg2_id ? ID_BIT : 8'h00) |
                      (with_crc ? 8'h00 : PROT_ABSENT);
    if (realign) begin
      hdr[BYTE_LEN_MID]      = flen[12:5];
      hdr[BYTE_LEN_LO][7:3]  = flen[4:0];
    end else begin
      hdr[BYTE_LEN_HI][1:0]  = flen[12:11];
      hdr[BYTE_LEN_MID]      = flen[10:3];
      hdr[BYTE_LEN_LO][7:5]  = flen[2:0];
    end
    for (int i = 0; i < nbytes; i++) send_word(hdr[i]);
    for (int i = 0; i < body_len; i++) send_word(8'($urandom_range(0, 255)));
    frame_words += nbytes + body_len;
    frame_count++;
    if (short_len) short_count++;
  endtask

  // Sync byte followed by a second byte that fails the mask and is not a sync byte
  task automatic send_sync_miss();
    logic [7:0] b;
    send_word(SYNC_BYTE);
    do b = 8'($urandom_range(0, 255));
    while ((b & SYNC2_MASK) == SYNC2_VALUE || b == SYNC_BYTE);
    send_word(b);
    miss_count++;
  endtask

  // Stop offering, let every expected word out, then allow for trailing work
  task automatic wait_idle();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Change registers only with the block drained and hunting between frames
  task automatic apply_setting(input bit legacy, input bit strip);
    wait_idle();
    if (!between_frames) begin
      while (!between_frames) send_word(8'h00);
      wait_idle();
    end
    cfg_write <= 1'b1;
    cfg_index <= CFG_LEGACY;
    cfg_data  <= legacy;
    @(negedge clk);
    cfg_index <= CFG_STRIP;
    cfg_data  <= strip;
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_legacy_now = legacy;
    settings_count++;
  endtask

  // Random stream: mostly well-formed frames, some short, broken and noise
  task automatic run_random(input int goal);
    int pick;
    int body;
    while (frame_words < goal) begin
      pick = $urandom_range(0, 19);
      body = ($urandom_range(0, 15) == 0) ? int'($urandom_range(30, 60))
                                          : int'($urandom_range(0, 12));
      if (pick < 14) begin
        if (pick == 0) send_word(SYNC_BYTE);
        send_frame(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), body, 1'b0);
      end else if (pick < 16) begin
        send_frame(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 0, 1'b1);
      end else if (pick < 18) begin
        send_sync_miss();
      end else begin
        repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 254)));
      end
    end
  endtask

  // Result side: random pops, one long hold-off on request
  initial begin : sink
    int gap;
    int mode_left;
    bit eager;
    bit stall_done;
    gap        = 0;
    mode_left  = 0;
    eager      = 1'b0;
    stall_done = 1'b0;
    pop        = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (stall_request && !stall_done) begin
        stall_done = 1'b1;
        gap = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(40, 200);
        eager = ($urandom_range(0, 3) == 0);
      end
      mode_left--;
      if (gap > 0) begin
        gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!eager) gap = idle_len();
      end
    end
  end

  // Main sequence
  initial begin
    rst           = 1'b1;
    push          = 1'b0;
    in_byte       = '0;
    cfg_write     = 1'b0;
    cfg_index     = CFG_LEGACY;
    cfg_data      = 1'b0;
    sender_steady = 1'b0;
    stall_request = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // standard layout, payload only: empty marker, short length, sync miss, doubled sync
    apply_setting(1'b0, 1'b1);
    send_frame(1'b0, 1'b0, 0, 1'b0);
    send_frame(1'b0, 1'b0, 0, 1'b1);
    send_sync_miss();
    send_word(SYNC_BYTE);
    send_frame(1'b1, 1'b1, 1, 1'b0);

    // standard layout with header replay
    apply_setting(1'b0, 1'b0);
    send_frame(1'b0, 1'b1, 0, 1'b0);
    send_frame(1'b0, 1'b0, 2, 1'b0);

    // legacy layout, payload only: carry byte alone, realigned payload, aligned header
    apply_setting(1'b1, 1'b1);
    send_frame(1'b0, 1'b0, 0, 1'b0);
    send_frame(1'b0, 1'b1, 2, 1'b0);
    send_frame(1'b1, 1'b0, 1, 1'b0);

    // legacy layout with header replay, widest header
    apply_setting(1'b1, 1'b0);
    send_frame(1'b0, 1'b1, 0, 1'b0);
    send_frame(1'b0, 1'b0, 1, 1'b0);

    // random phases; the first one runs under a long receiver hold-off
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      if (p == 0) stall_request = 1'b1;
      sender_steady = ($urandom_range(0, 3) == 0);
      run_random(frame_words + RANDOM_WORDS / RANDOM_PHASES);
    end
    wait_idle();

    $display("Ran %0d frames (%0d short, %0d sync misses) over %0d register settings,",
             frame_count, short_count, miss_count, settings_count);
    $display("%0d input words sent and %0d result words checked.", sent_words, words_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/adts_pkg.sv
rtl/adts_ram.sv
rtl/adts_front.sv
rtl/adts_cmd_fifo.sv
rtl/adts_back.sv
rtl/adts_frame_extractor.sv
bench/adts_frame_checker.sv
bench/adts_frame_extractor_tb.sv
